/* rtl/core/pftd_pkg.sv */
// shared types and constants for the pixel threshold / duotone filter
// no dependencies; every other file in rtl/core refers to this package by scoped names
package pftd_pkg;

	localparam int DEF_FRAME_ROWS  = 640;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam int PIX_W       = 8;
	localparam int ROW_FIELD_W = 12;
	localparam int LEVEL_W     = 7;
	localparam int MODE_W      = 3;
	localparam int COLOUR_W    = 25;
	localparam int RGB_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_CH      = 3;

	// channel order inside packed pixel vectors and colour words
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	// filter modes
	localparam logic [MODE_W-1:0] MODE_PASS     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BRIGHT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CONTRAST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INVERT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_THRESH   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUOTONE  = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_START   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_END     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_START = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_END   = 3'd7;

	localparam int SET_BIT = 24;

	// luma coefficients, 14 fractional bits
	localparam int LUMA_B     = 1868;
	localparam int LUMA_G     = 9617;
	localparam int LUMA_R     = 4899;
	localparam int LUMA_ROUND = 8192;
	localparam int LUMA_SHIFT = 14;
	localparam int LUMA_SUM_W = 22;

	localparam int LEVEL_MID = 50;
	localparam int PIX_MAX   = 255;

	// contrast: ch * level / 50 via reciprocal, exact for products below 2^15
	localparam int CV_W           = 15;
	localparam int CP_W           = 31;
	localparam int CQ_W           = 10;
	localparam int CONTRAST_RECIP = 41944;
	localparam int CONTRAST_SHIFT = 21;
	localparam int CONTRAST_HALF  = 25;

	typedef enum logic [2:0] {
		OP_PASS     = 3'd0,
		OP_BRIGHT   = 3'd1,
		OP_CONTRAST = 3'd2,
		OP_INVERT   = 3'd3,
		OP_BLEND    = 3'd4
	} pftd_op_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [LEVEL_W-1:0]  brightness;
		logic [LEVEL_W-1:0]  contrast;
		logic [PIX_W-1:0]    threshold;
		logic [COLOUR_W-1:0] dark_start;
		logic [COLOUR_W-1:0] dark_end;
		logic [COLOUR_W-1:0] bright_start;
		logic [COLOUR_W-1:0] bright_end;
	} pftd_cfg_t;

	// one classified pixel as it travels from front to back
	typedef struct packed {
		pftd_op_t                      op;
		logic [NUM_CH-1:0][PIX_W-1:0]  pix;
		logic [ROW_FIELD_W-1:0]        row;
		logic [RGB_W-1:0]              c0;
		logic [RGB_W-1:0]              c1;
	} pftd_item_t;

endpackage

/* rtl/core/pftd_front.sv */
// front end: takes pixels, computes luma, clamps the row and classifies the operation
// depends on pftd_pkg
module pftd_front #(
	parameter int FRAME_ROWS = pftd_pkg::DEF_FRAME_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pftd_pkg::PIX_W-1:0]      pixel_blue,
	input  logic [pftd_pkg::PIX_W-1:0]      pixel_green,
	input  logic [pftd_pkg::PIX_W-1:0]      pixel_red,
	input  logic [pftd_pkg::ROW_FIELD_W-1:0] pixel_row,
	input  pftd_pkg::pftd_cfg_t             cfg,
	input  logic                            q_full,
	output logic                            push,
	output pftd_pkg::pftd_item_t            item
);

	localparam logic [pftd_pkg::ROW_FIELD_W-1:0] SPAN_V =
		pftd_pkg::ROW_FIELD_W'(FRAME_ROWS - 1);

	logic                                              accept;
	logic                                              valid_s1;
	logic [pftd_pkg::NUM_CH-1:0][pftd_pkg::PIX_W-1:0]  pix_s1;
	logic [pftd_pkg::ROW_FIELD_W-1:0]                  row_s1;
	logic [pftd_pkg::PIX_W-1:0]                        luma_s1;
	logic [pftd_pkg::LUMA_SUM_W-1:0]                   luma_sum;
	logic                                              is_bright;
	logic                                              dark_ok;
	logic                                              bright_ok;
	logic [pftd_pkg::PIX_W-1:0]                        gray;

	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_full;

	assign luma_sum =
		pftd_pkg::LUMA_SUM_W'(pixel_blue)  * pftd_pkg::LUMA_SUM_W'(pftd_pkg::LUMA_B) +
		pftd_pkg::LUMA_SUM_W'(pixel_green) * pftd_pkg::LUMA_SUM_W'(pftd_pkg::LUMA_G) +
		pftd_pkg::LUMA_SUM_W'(pixel_red)   * pftd_pkg::LUMA_SUM_W'(pftd_pkg::LUMA_R) +
		pftd_pkg::LUMA_SUM_W'(pftd_pkg::LUMA_ROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1[pftd_pkg::CH_BLUE]  <= pixel_blue;
			pix_s1[pftd_pkg::CH_GREEN] <= pixel_green;
			pix_s1[pftd_pkg::CH_RED]   <= pixel_red;
			row_s1  <= (pixel_row > SPAN_V) ? SPAN_V : pixel_row;
			luma_s1 <= luma_sum[pftd_pkg::LUMA_SHIFT +: pftd_pkg::PIX_W];
		end
	end

	assign is_bright = luma_s1 > cfg.threshold;
	assign gray      = {pftd_pkg::PIX_W{is_bright}};
	assign dark_ok   = cfg.dark_start[pftd_pkg::SET_BIT] && cfg.dark_end[pftd_pkg::SET_BIT];
	assign bright_ok = cfg.bright_start[pftd_pkg::SET_BIT]
		&& cfg.bright_end[pftd_pkg::SET_BIT];

	always_comb begin
		item.op  = pftd_pkg::OP_PASS;
		item.pix = pix_s1;
		item.row = row_s1;
		item.c0  = cfg.dark_start[pftd_pkg::RGB_W-1:0];
		item.c1  = cfg.dark_end[pftd_pkg::RGB_W-1:0];
		unique case (cfg.mode)
			pftd_pkg::MODE_BRIGHT:   item.op = pftd_pkg::OP_BRIGHT;
			pftd_pkg::MODE_CONTRAST: item.op = pftd_pkg::OP_CONTRAST;
			pftd_pkg::MODE_INVERT:   item.op = pftd_pkg::OP_INVERT;
			pftd_pkg::MODE_THRESH: begin
				item.pix = {pftd_pkg::NUM_CH{gray}};
			end
			pftd_pkg::MODE_DUOTONE: begin
				item.pix = {pftd_pkg::NUM_CH{gray}};
				if (!is_bright && dark_ok) begin
					item.op = pftd_pkg::OP_BLEND;
				end else if (is_bright && bright_ok) begin
					item.op = pftd_pkg::OP_BLEND;
					item.c0 = cfg.bright_start[pftd_pkg::RGB_W-1:0];
					item.c1 = cfg.bright_end[pftd_pkg::RGB_W-1:0];
				end
			end
			// pass and the unused modes
			default: item.op = pftd_pkg::OP_PASS;
		endcase
	end

endmodule

/* rtl/core/pftd_queue.sv */
// short queue between the front and back ends
// depends on pftd_pkg for the item type
module pftd_queue #(
	parameter int DEPTH = pftd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pftd_pkg::pftd_item_t wr_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output pftd_pkg::pftd_item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CAP   = CNT_W'(DEPTH);

	pftd_pkg::pftd_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = count_q == CAP;
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/pftd_back.sv */
// back end: executes the classified operation, three stages, never stalls
// depends on pftd_pkg; row blend divides by FRAME_ROWS-1 through a reciprocal
module pftd_back #(
	parameter int FRAME_ROWS = pftd_pkg::DEF_FRAME_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pftd_pkg::pftd_cfg_t          cfg,
	input  logic                         q_empty,
	input  pftd_pkg::pftd_item_t         q_item,
	output logic                         q_pop,
	output logic [pftd_pkg::PIX_W-1:0]   out_blue,
	output logic [pftd_pkg::PIX_W-1:0]   out_green,
	output logic [pftd_pkg::PIX_W-1:0]   out_red,
	output logic                         done
);

	localparam int SPAN   = FRAME_ROWS - 1;
	localparam int ROW_W  = $clog2(FRAME_ROWS);
	localparam int NUM_W  = pftd_pkg::PIX_W + ROW_W;
	localparam int K_W    = NUM_W + 1;
	localparam int PROD_W = NUM_W + K_W;
	localparam int RECIP  = (1 << NUM_W) / SPAN;
	localparam int NC     = pftd_pkg::NUM_CH;
	localparam int PW     = pftd_pkg::PIX_W;

	logic [ROW_W-1:0]                row_n;
	logic [ROW_W-1:0]                span_minus;

	logic                            v_s1;
	pftd_pkg::pftd_op_t              op_s1;
	logic [NC-1:0][PW-1:0]           direct_s1;
	logic [NC-1:0][pftd_pkg::CV_W-1:0] cv_s1;
	logic [NC-1:0][NUM_W-1:0]        num_s1;

	logic                            v_s2;
	pftd_pkg::pftd_op_t              op_s2;
	logic [NC-1:0][PW-1:0]           direct_s2;
	logic [NC-1:0][pftd_pkg::CV_W-1:0] cv_s2;
	logic [NC-1:0][pftd_pkg::CP_W-1:0] cp_s2;
	logic [NC-1:0][NUM_W-1:0]        num_s2;
	logic [NC-1:0][PROD_W-1:0]       bp_s2;

	logic [NC-1:0][PW-1:0]           direct_c;
	logic [NC-1:0][pftd_pkg::CV_W-1:0] cv_c;
	logic [NC-1:0][NUM_W-1:0]        num_c;
	logic [NC-1:0][PW-1:0]           res_c;

	logic [NC-1:0][PW-1:0]           out_q;
	logic                            done_q;

	assign q_pop      = !q_empty;
	assign row_n      = q_item.row[ROW_W-1:0];
	assign span_minus = ROW_W'(SPAN) - row_n;

	// stage 1: narrow operations, contrast product, blend numerator
	always_comb begin
		logic [PW:0] bsum;
		logic [PW:0] bdiff;
		logic [PW-1:0] ch;
		logic [PW-1:0] ca;
		logic [PW-1:0] cb;
		for (int i = 0; i < NC; i++) begin
			ch = q_item.pix[i];
			ca = q_item.c0[PW*i +: PW];
			cb = q_item.c1[PW*i +: PW];
			bsum  = (PW+1)'(ch) + (PW+1)'(cfg.brightness);
			bdiff = bsum - (PW+1)'(pftd_pkg::LEVEL_MID);
			unique case (q_item.op)
				pftd_pkg::OP_BRIGHT: begin
					if (bsum < (PW+1)'(pftd_pkg::LEVEL_MID)) begin
						direct_c[i] = '0;
					end else if (bdiff > (PW+1)'(pftd_pkg::PIX_MAX)) begin
						direct_c[i] = PW'(pftd_pkg::PIX_MAX);
					end else begin
						direct_c[i] = bdiff[PW-1:0];
					end
				end
				pftd_pkg::OP_INVERT: direct_c[i] = ~ch;
				default:             direct_c[i] = ch;
			endcase
			cv_c[i]  = pftd_pkg::CV_W'(ch) * pftd_pkg::CV_W'(cfg.contrast);
			num_c[i] = NUM_W'(ca) * NUM_W'(span_minus) + NUM_W'(cb) * NUM_W'(row_n);
		end
	end

	// stage 3: quotient correction and contrast rounding
	always_comb begin
		logic [pftd_pkg::CQ_W-1:0] cq;
		logic [pftd_pkg::CV_W-1:0] cr;
		logic                      up;
		logic [pftd_pkg::CQ_W:0]   cq_r;
		logic [PW-1:0]             q0;
		logic [NUM_W-1:0]          brem;
		for (int i = 0; i < NC; i++) begin
			cq   = cp_s2[i][pftd_pkg::CONTRAST_SHIFT +: pftd_pkg::CQ_W];
			cr   = cv_s2[i] - pftd_pkg::CV_W'(cq) * pftd_pkg::CV_W'(pftd_pkg::LEVEL_MID);
			up   = (cr > pftd_pkg::CV_W'(pftd_pkg::CONTRAST_HALF))
				|| ((cr == pftd_pkg::CV_W'(pftd_pkg::CONTRAST_HALF)) && cq[0]);
			cq_r = (pftd_pkg::CQ_W+1)'(cq) + (pftd_pkg::CQ_W+1)'(up);
			q0   = bp_s2[i][NUM_W +: PW];
			// reciprocal underestimates by at most one
			brem = num_s2[i] - NUM_W'(q0) * NUM_W'(SPAN);
			unique case (op_s2)
				pftd_pkg::OP_CONTRAST: begin
					res_c[i] = (cq_r > (pftd_pkg::CQ_W+1)'(pftd_pkg::PIX_MAX))
						? PW'(pftd_pkg::PIX_MAX) : cq_r[PW-1:0];
				end
				pftd_pkg::OP_BLEND: begin
					res_c[i] = (brem >= NUM_W'(SPAN)) ? q0 + 1'b1 : q0;
				end
				default: res_c[i] = direct_s2[i];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= !q_empty;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!q_empty) begin
			op_s1     <= q_item.op;
			direct_s1 <= direct_c;
			cv_s1     <= cv_c;
			num_s1    <= num_c;
		end
		if (v_s1) begin
			op_s2     <= op_s1;
			direct_s2 <= direct_s1;
			cv_s2     <= cv_s1;
			num_s2    <= num_s1;
			for (int i = 0; i < NC; i++) begin
				cp_s2[i] <= pftd_pkg::CP_W'(cv_s1[i]) * pftd_pkg::CP_W'(pftd_pkg::CONTRAST_RECIP);
				bp_s2[i] <= PROD_W'(num_s1[i]) * PROD_W'(RECIP);
			end
		end
		if (v_s2) begin
			out_q <= res_c;
		end
	end

	assign out_blue  = out_q[pftd_pkg::CH_BLUE];
	assign out_green = out_q[pftd_pkg::CH_GREEN];
	assign out_red   = out_q[pftd_pkg::CH_RED];
	assign done      = done_q;

endmodule

/* rtl/core/pixel_filter_threshold_duotone.sv */
// top level of the pixel threshold / duotone filter: register file, front, queue, back
// depends on pftd_pkg, pftd_front, pftd_queue, pftd_back
//
//   channel  | handshake                           | payload
//   ---------+-------------------------------------+---------------------------------
//   pixel in | start, busy (transfer: start & !busy) | pixel_blue/green/red, pixel_row
//   result   | done (one-cycle strobe)             | out_blue, out_green, out_red
//   config   | cfg_valid, cfg_ready                | cfg_index, cfg_data
//
// one pixel per clock while busy is low; after its transfer, a result passes the luma stage,
// one queue slot, and the back end's three stages (products, reciprocal multiply, output).
// arst_n clears all control state and loads the register reset values; no clearing pass.
// the back end never stalls, so busy only rises if the queue ever fills; cfg_ready is
// always high; the user must write registers only while no pixel is in flight; unchecked.
module pixel_filter_threshold_duotone #(
	parameter int FRAME_ROWS  = pftd_pkg::DEF_FRAME_ROWS,
	parameter int QUEUE_DEPTH = pftd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pftd_pkg::PIX_W-1:0]        pixel_blue,
	input  logic [pftd_pkg::PIX_W-1:0]        pixel_green,
	input  logic [pftd_pkg::PIX_W-1:0]        pixel_red,
	input  logic [pftd_pkg::ROW_FIELD_W-1:0]  pixel_row,
	output logic [pftd_pkg::PIX_W-1:0]        out_blue,
	output logic [pftd_pkg::PIX_W-1:0]        out_green,
	output logic [pftd_pkg::PIX_W-1:0]        out_red,
	output logic                              done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pftd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pftd_pkg::COLOUR_W-1:0]     cfg_data
);

	pftd_pkg::pftd_cfg_t  cfg_q;
	pftd_pkg::pftd_item_t push_item;
	pftd_pkg::pftd_item_t head_item;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= pftd_pkg::MODE_PASS;
			cfg_q.brightness   <= pftd_pkg::LEVEL_W'(pftd_pkg::LEVEL_MID);
			cfg_q.contrast     <= pftd_pkg::LEVEL_W'(pftd_pkg::LEVEL_MID);
			cfg_q.threshold    <= 8'd127;
			cfg_q.dark_start   <= '0;
			cfg_q.dark_end     <= '0;
			cfg_q.bright_start <= pftd_pkg::COLOUR_W'(25'h0FF_FFFF);
			cfg_q.bright_end   <= pftd_pkg::COLOUR_W'(25'h0FF_FFFF);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pftd_pkg::REG_MODE:         cfg_q.mode <= cfg_data[pftd_pkg::MODE_W-1:0];
				pftd_pkg::REG_BRIGHTNESS:   cfg_q.brightness <= cfg_data[pftd_pkg::LEVEL_W-1:0];
				pftd_pkg::REG_CONTRAST:     cfg_q.contrast <= cfg_data[pftd_pkg::LEVEL_W-1:0];
				pftd_pkg::REG_THRESHOLD:    cfg_q.threshold <= cfg_data[pftd_pkg::PIX_W-1:0];
				pftd_pkg::REG_DARK_START:   cfg_q.dark_start <= cfg_data;
				pftd_pkg::REG_DARK_END:     cfg_q.dark_end <= cfg_data;
				pftd_pkg::REG_BRIGHT_START: cfg_q.bright_start <= cfg_data;
				pftd_pkg::REG_BRIGHT_END:   cfg_q.bright_end <= cfg_data;
			endcase
		end
	end

	pftd_front #(
		.FRAME_ROWS (FRAME_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel_blue  (pixel_blue),
		.pixel_green (pixel_green),
		.pixel_red   (pixel_red),
		.pixel_row   (pixel_row),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.push        (q_push),
		.item        (push_item)
	);

	pftd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (push_item),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_item (head_item)
	);

	pftd_back #(
		.FRAME_ROWS (FRAME_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.done      (done)
	);

`ifndef NO_ASSERTIONS
	// every transfer yields its result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result missing 5 cycles after pixel transfer");

	// no result without an earlier transfer
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result strobe without matching pixel transfer");

	// back end drains every cycle, so the front never backs up
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("front end stalled although back end never stalls");
`endif

endmodule

/* bench/tb_pixel_filter_threshold_duotone.sv */
`timescale 1ns / 100ps
// self-checking bench for pixel_filter_threshold_duotone: directed corners, then random
// settings and pixels with gaps on the sender; needs pftd_pkg and the block's rtl
module tb_pixel_filter_threshold_duotone;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int ROW_SPAN      = pftd_pkg::DEF_FRAME_ROWS - 1;
	localparam int MAX_PRINTS    = 100;
	localparam logic [pftd_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [pftd_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [pftd_pkg::PIX_W-1:0]       blue;
		logic [pftd_pkg::PIX_W-1:0]       green;
		logic [pftd_pkg::PIX_W-1:0]       red;
		logic [pftd_pkg::ROW_FIELD_W-1:0] row;
	} pixel_item_t;

	typedef struct packed {
		logic [pftd_pkg::PIX_W-1:0] blue;
		logic [pftd_pkg::PIX_W-1:0] green;
		logic [pftd_pkg::PIX_W-1:0] red;
	} rgb_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [pftd_pkg::PIX_W-1:0]       pixel_blue = '0;
	logic [pftd_pkg::PIX_W-1:0]       pixel_green = '0;
	logic [pftd_pkg::PIX_W-1:0]       pixel_red = '0;
	logic [pftd_pkg::ROW_FIELD_W-1:0] pixel_row = '0;
	logic [pftd_pkg::PIX_W-1:0]       out_blue;
	logic [pftd_pkg::PIX_W-1:0]       out_green;
	logic [pftd_pkg::PIX_W-1:0]       out_red;
	logic                             done;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [pftd_pkg::CFG_IDX_W-1:0]   cfg_index = pftd_pkg::REG_MODE;
	logic [pftd_pkg::COLOUR_W-1:0]    cfg_data = '0;

	pixel_item_t         pending_pixels[$];
	rgb_t                expected_rgb[$];
	pftd_pkg::pftd_cfg_t cfg_shadow;
	logic                gaps_on = 1'b1;
	int                  mismatch_count = 0;
	int unsigned         cycle_count = 0;

	pixel_filter_threshold_duotone dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_blue(pixel_blue), .pixel_green(pixel_green), .pixel_red(pixel_red),
		.pixel_row(pixel_row),
		.out_blue(out_blue), .out_green(out_green), .out_red(out_red), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic logic [pftd_pkg::PIX_W-1:0] offset_channel(
			input logic [pftd_pkg::PIX_W-1:0] ch);
		int v;
		v = int'(ch) + int'(cfg_shadow.brightness) - pftd_pkg::LEVEL_MID;
		if (v < 0)
			v = 0;
		else if (v > pftd_pkg::PIX_MAX)
			v = pftd_pkg::PIX_MAX;
		return v[pftd_pkg::PIX_W-1:0];
	endfunction

	// ch * level / 50, ties go to the even quotient
	function automatic logic [pftd_pkg::PIX_W-1:0] scale_channel(
			input logic [pftd_pkg::PIX_W-1:0] ch);
		int v, q, r;
		v = int'(ch) * int'(cfg_shadow.contrast);
		q = v / pftd_pkg::LEVEL_MID;
		r = v % pftd_pkg::LEVEL_MID;
		if (r > pftd_pkg::LEVEL_MID / 2 || (r == pftd_pkg::LEVEL_MID / 2 && q % 2 == 1))
			q++;
		if (q > pftd_pkg::PIX_MAX)
			q = pftd_pkg::PIX_MAX;
		return q[pftd_pkg::PIX_W-1:0];
	endfunction

	function automatic logic [pftd_pkg::PIX_W-1:0] blend_channel(
			input logic [pftd_pkg::PIX_W-1:0] top,
			input logic [pftd_pkg::PIX_W-1:0] bottom, input int row);
		int v;
		v = (int'(top) * (ROW_SPAN - row) + int'(bottom) * row) / ROW_SPAN;
		return v[pftd_pkg::PIX_W-1:0];
	endfunction

	function automatic rgb_t filter_pixel(input pixel_item_t p);
		rgb_t                          res;
		int                            luma, row;
		logic                          bright, use_grad;
		logic [pftd_pkg::COLOUR_W-1:0] c0, c1;
		logic [pftd_pkg::PIX_W-1:0]    gray;
		res.blue = p.blue;
		res.green = p.green;
		res.red = p.red;
		case (cfg_shadow.mode)
			pftd_pkg::MODE_BRIGHT: begin
				res.blue = offset_channel(p.blue);
				res.green = offset_channel(p.green);
				res.red = offset_channel(p.red);
			end
			pftd_pkg::MODE_CONTRAST: begin
				res.blue = scale_channel(p.blue);
				res.green = scale_channel(p.green);
				res.red = scale_channel(p.red);
			end
			pftd_pkg::MODE_INVERT: begin
				res.blue = ~p.blue;
				res.green = ~p.green;
				res.red = ~p.red;
			end
			pftd_pkg::MODE_THRESH, pftd_pkg::MODE_DUOTONE: begin
				luma = (pftd_pkg::LUMA_B * int'(p.blue) + pftd_pkg::LUMA_G * int'(p.green)
					+ pftd_pkg::LUMA_R * int'(p.red) + pftd_pkg::LUMA_ROUND)
					>>> pftd_pkg::LUMA_SHIFT;
				bright = luma > int'(cfg_shadow.threshold);
				gray = bright ? 8'hFF : 8'h00;
				res.blue = gray;
				res.green = gray;
				res.red = gray;
				if (cfg_shadow.mode == pftd_pkg::MODE_DUOTONE) begin
					// rows past the frame bottom clamp to the last row
					row = (int'(p.row) > ROW_SPAN) ? ROW_SPAN : int'(p.row);
					use_grad = 1'b0;
					c0 = '0;
					c1 = '0;
					if (!bright && cfg_shadow.dark_start[pftd_pkg::SET_BIT]
							&& cfg_shadow.dark_end[pftd_pkg::SET_BIT]) begin
						c0 = cfg_shadow.dark_start;
						c1 = cfg_shadow.dark_end;
						use_grad = 1'b1;
					end else if (bright && cfg_shadow.bright_start[pftd_pkg::SET_BIT]
							&& cfg_shadow.bright_end[pftd_pkg::SET_BIT]) begin
						c0 = cfg_shadow.bright_start;
						c1 = cfg_shadow.bright_end;
						use_grad = 1'b1;
					end
					if (use_grad) begin
						res.red = blend_channel(c0[23:16], c1[23:16], row);
						res.green = blend_channel(c0[15:8], c1[15:8], row);
						res.blue = blend_channel(c0[7:0], c1[7:0], row);
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// sender: a pixel transfers on start & !busy
	always @(posedge clk) begin : drive_pixels
		pixel_item_t seen, nxt;
		if (arst_n) begin
			if (start && !busy) begin
				seen.blue = pixel_blue;
				seen.green = pixel_green;
				seen.red = pixel_red;
				seen.row = pixel_row;
				expected_rgb.insert(expected_rgb.size(), filter_pixel(seen));
			end
			if (!start || !busy) begin
				if (pending_pixels.size() > 0 && !(gaps_on && $urandom_range(99) < 13)) begin
					nxt = pending_pixels.pop_front();
					start <= 1'b1;
					pixel_blue <= nxt.blue;
					pixel_green <= nxt.green;
					pixel_red <= nxt.red;
					pixel_row <= nxt.row;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		rgb_t want;
		if (arst_n && done) begin
			if (expected_rgb.size() == 0) begin
				report_mismatch("result with nothing pending",
					int'({out_red, out_green, out_blue}), -1);
			end else begin
				want = expected_rgb.pop_front();
				if (out_blue !== want.blue)
					report_mismatch("out_blue", int'(out_blue), int'(want.blue));
				if (out_green !== want.green)
					report_mismatch("out_green", int'(out_green), int'(want.green));
				if (out_red !== want.red)
					report_mismatch("out_red", int'(out_red), int'(want.red));
			end
		end
	end

	task automatic write_reg(input logic [pftd_pkg::CFG_IDX_W-1:0] idx,
			input logic [pftd_pkg::COLOUR_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pftd_pkg::REG_MODE:         cfg_shadow.mode = val[pftd_pkg::MODE_W-1:0];
			pftd_pkg::REG_BRIGHTNESS:   cfg_shadow.brightness = val[pftd_pkg::LEVEL_W-1:0];
			pftd_pkg::REG_CONTRAST:     cfg_shadow.contrast = val[pftd_pkg::LEVEL_W-1:0];
			pftd_pkg::REG_THRESHOLD:    cfg_shadow.threshold = val[pftd_pkg::PIX_W-1:0];
			pftd_pkg::REG_DARK_START:   cfg_shadow.dark_start = val;
			pftd_pkg::REG_DARK_END:     cfg_shadow.dark_end = val;
			pftd_pkg::REG_BRIGHT_START: cfg_shadow.bright_start = val;
			pftd_pkg::REG_BRIGHT_END:   cfg_shadow.bright_end = val;
			default: ;
		endcase
	endtask

	task automatic queue_pixel(input int b, input int g, input int r, input int row);
		pixel_item_t p;
		p.blue = b[pftd_pkg::PIX_W-1:0];
		p.green = g[pftd_pkg::PIX_W-1:0];
		p.red = r[pftd_pkg::PIX_W-1:0];
		p.row = row[pftd_pkg::ROW_FIELD_W-1:0];
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	// sender holds off until every pixel has come back, then lets the pipe settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_pixels.size() != 0 || start || expected_rgb.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [pftd_pkg::LEVEL_W-1:0] pick_level();
		case ($urandom_range(9))
			0: return '0;
			1: return 7'd100;
			2: return 7'd127;
			default: return pftd_pkg::LEVEL_W'($urandom_range(127));
		endcase
	endfunction

	function automatic logic [pftd_pkg::COLOUR_W-1:0] pick_colour();
		logic [pftd_pkg::COLOUR_W-1:0] c;
		c = pftd_pkg::COLOUR_W'($urandom);
		c[pftd_pkg::SET_BIT] = ($urandom_range(5) != 0);
		return c;
	endfunction

	function automatic int pick_row();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return $urandom_range(ROW_SPAN);
		else if (sel == 6) begin
			case ($urandom_range(4))
				0: return 0;
				1: return ROW_SPAN - 1;
				2: return ROW_SPAN;
				3: return ROW_SPAN + 1;
				default: return 4095;
			endcase
		end
		return $urandom_range(4095);
	endfunction

	initial begin : run_phases
		int ph, n, count, v;
		logic [pftd_pkg::MODE_W-1:0] mode_sel;
		cfg_shadow.mode = pftd_pkg::MODE_PASS;
		cfg_shadow.brightness = 7'd50;
		cfg_shadow.contrast = 7'd50;
		cfg_shadow.threshold = 8'd127;
		cfg_shadow.dark_start = 25'h0000000;
		cfg_shadow.dark_end = 25'h0000000;
		cfg_shadow.bright_start = 25'h0FFFFFF;
		cfg_shadow.bright_end = 25'h0FFFFFF;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: pass-through at the field extremes
		queue_pixel(0, 0, 0, 0);
		queue_pixel(255, 255, 255, 4095);
		wait_idle();

		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(pftd_pkg::MODE_BRIGHT));
		write_reg(pftd_pkg::REG_BRIGHTNESS, 25'd100);
		queue_pixel(10, 205, 255, 1);
		wait_idle();
		write_reg(pftd_pkg::REG_BRIGHTNESS, 25'd0);
		queue_pixel(0, 49, 51, 2);
		wait_idle();
		write_reg(pftd_pkg::REG_BRIGHTNESS, 25'd127);
		queue_pixel(200, 100, 178, 3);
		wait_idle();

		// contrast saturation, zero gain, and ties rounding to even
		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(pftd_pkg::MODE_CONTRAST));
		write_reg(pftd_pkg::REG_CONTRAST, 25'd127);
		queue_pixel(255, 100, 1, 0);
		wait_idle();
		write_reg(pftd_pkg::REG_CONTRAST, 25'd0);
		queue_pixel(255, 128, 7, 0);
		wait_idle();
		write_reg(pftd_pkg::REG_CONTRAST, 25'd1);
		queue_pixel(25, 75, 125, 0);
		queue_pixel(26, 74, 175, 0);
		wait_idle();

		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(pftd_pkg::MODE_INVERT));
		queue_pixel(0, 128, 255, 7);
		wait_idle();

		// a gray pixel at the threshold is dark, one above is bright
		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(pftd_pkg::MODE_THRESH));
		queue_pixel(127, 127, 127, 0);
		queue_pixel(128, 128, 128, 0);
		wait_idle();
		write_reg(pftd_pkg::REG_THRESHOLD, 25'd255);
		queue_pixel(255, 255, 255, 0);
		wait_idle();
		write_reg(pftd_pkg::REG_THRESHOLD, 25'd0);
		queue_pixel(0, 0, 0, 0);
		queue_pixel(1, 1, 1, 0);
		wait_idle();

		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(pftd_pkg::MODE_DUOTONE));
		write_reg(pftd_pkg::REG_THRESHOLD, 25'd127);
		write_reg(pftd_pkg::REG_DARK_START, 25'h1102030);
		write_reg(pftd_pkg::REG_DARK_END, 25'h1F0E0D0);
		write_reg(pftd_pkg::REG_BRIGHT_START, 25'h1FF8000);
		write_reg(pftd_pkg::REG_BRIGHT_END, 25'h10080FF);
		queue_pixel(0, 0, 0, 0);
		queue_pixel(0, 0, 0, ROW_SPAN);
		queue_pixel(10, 20, 30, 4095);
		queue_pixel(255, 255, 255, 320);
		wait_idle();
		// incomplete colour pairs fall back to the binary gray
		write_reg(pftd_pkg::REG_DARK_START, 25'h0102030);
		write_reg(pftd_pkg::REG_BRIGHT_END, 25'h00080FF);
		queue_pixel(0, 0, 0, 100);
		queue_pixel(255, 255, 255, 100);
		wait_idle();

		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(MODE_SPARE_6));
		queue_pixel(1, 2, 3, 4);
		wait_idle();
		write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(MODE_SPARE_7));
		queue_pixel(250, 251, 252, 4094);
		wait_idle();

		for (ph = 0; ph < 22; ph++) begin
			if (ph < 8)
				mode_sel = ph[pftd_pkg::MODE_W-1:0];
			else if ($urandom_range(3) == 0)
				mode_sel = pftd_pkg::MODE_W'($urandom_range(7));
			else
				mode_sel = $urandom_range(1) ? pftd_pkg::MODE_DUOTONE : pftd_pkg::MODE_THRESH;
			write_reg(pftd_pkg::REG_MODE, pftd_pkg::COLOUR_W'(mode_sel));
			write_reg(pftd_pkg::REG_BRIGHTNESS, pftd_pkg::COLOUR_W'(pick_level()));
			write_reg(pftd_pkg::REG_CONTRAST, pftd_pkg::COLOUR_W'(pick_level()));
			v = $urandom_range(9);
			write_reg(pftd_pkg::REG_THRESHOLD, (v == 0) ? 25'd0 : (v == 1) ? 25'd255
				: pftd_pkg::COLOUR_W'($urandom_range(255)));
			write_reg(pftd_pkg::REG_DARK_START, pick_colour());
			write_reg(pftd_pkg::REG_DARK_END, pick_colour());
			write_reg(pftd_pkg::REG_BRIGHT_START, pick_colour());
			write_reg(pftd_pkg::REG_BRIGHT_END, pick_colour());
			// one long phase streams back to back
			gaps_on = (ph != 10);
			count = (ph == 10) ? 150 : 57;
			for (n = 0; n < count; n++) begin
				if ($urandom_range(7) == 0) begin
					// near-gray pixels land around the threshold
					v = $urandom_range(255);
					queue_pixel(v, v ^ $urandom_range(1), v, pick_row());
				end else begin
					queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
						pick_row());
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/core/pftd_pkg.sv
rtl/core/pftd_front.sv
rtl/core/pftd_queue.sv
rtl/core/pftd_back.sv
rtl/core/pixel_filter_threshold_duotone.sv
bench/tb_pixel_filter_threshold_duotone.sv
